// ===== sv/cosdo_pkg.sv =====
// cosdo_pkg: shared codes, constants and the result beat type for the
// expedited SDO client. No dependencies.
package cosdo_pkg;

    // Input command codes
    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_FRAME = 2'd2;
    localparam logic [1:0] CMD_TICK  = 2'd3;

    // Result kinds
    localparam logic [1:0] KIND_TX     = 2'd0;
    localparam logic [1:0] KIND_DONE   = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;

    // Completion status
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_ABORT    = 3'd1;
    localparam logic [2:0] ST_UNEXP    = 3'd2;
    localparam logic [2:0] ST_TIMEOUT  = 3'd3;
    localparam logic [2:0] ST_BAD_SIZE = 3'd4;
    localparam logic [2:0] ST_BUSY     = 3'd5;

    // Configuration register indexes
    localparam logic REG_NODE_ID = 1'b0;
    localparam logic REG_TIMEOUT = 1'b1;

    // COB-ID bases
    localparam logic [10:0] ID_RSDO_BASE = 11'h600;
    localparam logic [10:0] ID_TSDO_BASE = 11'h580;

    // SDO command specifiers
    localparam logic [7:0] CS_DL_1B   = 8'h2F;
    localparam logic [7:0] CS_DL_2B   = 8'h2B;
    localparam logic [7:0] CS_DL_4B   = 8'h23;
    localparam logic [7:0] CS_UL_REQ  = 8'h40;
    localparam logic [7:0] CS_ABORT   = 8'h80;
    localparam logic [7:0] CS_DL_RESP = 8'h60;
    localparam logic [7:0] CS_UL_1B   = 8'h4F;
    localparam logic [7:0] CS_UL_2B   = 8'h4B;
    localparam logic [7:0] CS_UL_4B   = 8'h43;

    localparam logic [6:0]  NODE_ID_RST = 7'd1;
    localparam logic [15:0] TIMEOUT_RST = 16'd1000;

    typedef struct packed {
        logic [1:0]  kind;
        logic [10:0] tx_ident;
        logic [63:0] tx_bytes;
        logic [2:0]  status;
        logic [31:0] abort_code;
        logic [31:0] read_data;
        logic [2:0]  read_len;
    } t_result;

endpackage

// ===== sv/canopen_sdo_expedited_client.sv =====
// canopen_sdo_expedited_client: top level of the expedited SDO client.
// Depends on cosdo_pkg (codes, constants, t_result).
//
// Usage: one input channel (i_valid / o_stall) carries commands: start read,
// start write, received CAN frame, time tick. One output channel
// (o_valid / i_stall) carries results: a request frame to send, a finished
// transfer, or a rejected request. A beat moves on an edge with valid high
// and stall low. Commands that cause no result (ignored frames, ticks that
// only count down) produce no output beat.
// An accepted input beat's result is registered in the output stages.
// Throughput: one input beat per cycle while o_stall is low; all decode and
// matching is shallow compare logic in front of the result register.
// When the receiver stalls, the result waits in the output register and
// the next result drops into a one-entry skid register; o_stall rises only
// while that skid entry is full, so an input stall ends in the cycle after
// the receiver's stall does.
// Reset (synchronous, active low) empties both output stages, clears the
// pending transfer and restores node_id 1 and timeout_ticks 1000.
// Configuration: APB, node_id at byte 0, timeout_ticks at byte 4; write
// only while idle.
module canopen_sdo_expedited_client (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_cmd,
    input  logic [15:0] i_obj_index,
    input  logic [7:0]  i_obj_sub,
    input  logic [2:0]  i_write_len,
    input  logic [31:0] i_write_data,
    input  logic [10:0] i_rx_ident,
    input  logic [3:0]  i_rx_len,
    input  logic [63:0] i_rx_bytes,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [10:0] o_tx_ident,
    output logic [63:0] o_tx_bytes,
    output logic [2:0]  o_status,
    output logic [31:0] o_abort_code,
    output logic [31:0] o_read_data,
    output logic [2:0]  o_read_len,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Configuration registers
    logic [6:0]  r_node_id;
    logic [15:0] r_timeout;

    // Transfer state
    logic        r_busy,    n_busy;
    logic        r_is_wr,   n_is_wr;
    logic [15:0] r_idx,     n_idx;
    logic [7:0]  r_sub,     n_sub;
    logic [15:0] r_ticks,   n_ticks;

    // Output register and skid entry
    logic                 r_out_vld, r_skid_vld;
    cosdo_pkg::t_result   r_out, r_skid;

    logic                 w_accept, w_out_free, w_cfg_wr;
    logic                 w_has_res;
    cosdo_pkg::t_result   w_res;

    assign w_accept   = i_valid && !r_skid_vld;
    assign w_out_free = !r_out_vld || !i_stall;
    assign w_cfg_wr   = psel && penable && pwrite;

    // ---- request frame build ----
    logic [31:0] w_wr_payload;
    logic [7:0]  w_wr_cs;
    logic        w_wr_size_ok;

    assign w_wr_size_ok = (i_write_len == 3'd1) || (i_write_len == 3'd2)
                       || (i_write_len == 3'd4);
    assign w_wr_cs = (i_write_len == 3'd1) ? cosdo_pkg::CS_DL_1B :
                     (i_write_len == 3'd2) ? cosdo_pkg::CS_DL_2B : cosdo_pkg::CS_DL_4B;
    assign w_wr_payload = (i_write_len == 3'd1) ? {24'h0, i_write_data[7:0]} :
                          (i_write_len == 3'd2) ? {16'h0, i_write_data[15:0]} :
                          i_write_data;

    // ---- received frame decode ----
    logic [3:0]  w_dlc;
    logic [63:0] w_rx_data;
    logic [7:0]  w_b0;
    logic [31:0] w_hi;
    logic        w_match;
    logic [2:0]  w_rd_len;
    logic [31:0] w_rd_data;

    // a DLC above 8 counts as 8
    assign w_dlc = (i_rx_len > 4'd8) ? 4'd8 : i_rx_len;

    // bytes past the DLC read as zero
    for (genvar k = 0; k < 8; k++) begin : g_rx_mask
        assign w_rx_data[8*k +: 8] = (4'(k) < w_dlc) ? i_rx_bytes[8*k +: 8] : 8'h00;
    end

    assign w_b0 = w_rx_data[7:0];
    assign w_hi = w_rx_data[63:32];

    assign w_match = (i_rx_ident == (cosdo_pkg::ID_TSDO_BASE + {4'h0, r_node_id}))
                  && (w_dlc >= 4'd4)
                  && (w_rx_data[23:8] == r_idx)
                  && (w_rx_data[31:24] == r_sub);

    // upload length from the command byte, else whatever follows byte 3
    assign w_rd_len = (w_b0 == cosdo_pkg::CS_UL_1B) ? 3'd1 :
                      (w_b0 == cosdo_pkg::CS_UL_2B) ? 3'd2 :
                      (w_b0 == cosdo_pkg::CS_UL_4B) ? 3'd4 :
                      3'(w_dlc - 4'd4);

    for (genvar k = 0; k < 4; k++) begin : g_rd_mask
        assign w_rd_data[8*k +: 8] = (3'(k) < w_rd_len) ? w_hi[8*k +: 8] : 8'h00;
    end

    // ---- command handling ----
    always_comb begin
        n_busy    = r_busy;
        n_is_wr   = r_is_wr;
        n_idx     = r_idx;
        n_sub     = r_sub;
        n_ticks   = r_ticks;
        w_has_res = 1'b0;
        w_res     = '0;
        if (w_accept) begin
            unique case (i_cmd)
                cosdo_pkg::CMD_READ, cosdo_pkg::CMD_WRITE: begin
                    w_has_res = 1'b1;
                    if (r_busy) begin
                        w_res.kind   = cosdo_pkg::KIND_REJECT;
                        w_res.status = cosdo_pkg::ST_BUSY;
                    end else if (i_cmd == cosdo_pkg::CMD_WRITE && !w_wr_size_ok) begin
                        w_res.kind   = cosdo_pkg::KIND_REJECT;
                        w_res.status = cosdo_pkg::ST_BAD_SIZE;
                    end else begin
                        n_busy         = 1'b1;
                        n_is_wr        = (i_cmd == cosdo_pkg::CMD_WRITE);
                        n_idx          = i_obj_index;
                        n_sub          = i_obj_sub;
                        n_ticks        = r_timeout;
                        w_res.kind     = cosdo_pkg::KIND_TX;
                        w_res.tx_ident = cosdo_pkg::ID_RSDO_BASE + {4'h0, r_node_id};
                        w_res.tx_bytes = (i_cmd == cosdo_pkg::CMD_WRITE)
                            ? {w_wr_payload, i_obj_sub, i_obj_index, w_wr_cs}
                            : {32'h0, i_obj_sub, i_obj_index, cosdo_pkg::CS_UL_REQ};
                    end
                end
                cosdo_pkg::CMD_TICK: begin
                    if (r_busy) begin
                        if (r_ticks <= 16'd1) begin
                            n_busy       = 1'b0;
                            n_ticks      = '0;
                            w_has_res    = 1'b1;
                            w_res.kind   = cosdo_pkg::KIND_DONE;
                            w_res.status = cosdo_pkg::ST_TIMEOUT;
                        end else begin
                            n_ticks = r_ticks - 16'd1;
                        end
                    end
                end
                cosdo_pkg::CMD_FRAME: begin
                    if (r_busy && w_match) begin
                        n_busy     = 1'b0;
                        n_ticks    = '0;
                        w_has_res  = 1'b1;
                        w_res.kind = cosdo_pkg::KIND_DONE;
                        if (w_b0 == cosdo_pkg::CS_ABORT) begin
                            w_res.status     = cosdo_pkg::ST_ABORT;
                            w_res.abort_code = (w_dlc == 4'd8) ? w_hi : 32'h0;
                        end else if (r_is_wr) begin
                            w_res.status = (w_b0 == cosdo_pkg::CS_DL_RESP)
                                         ? cosdo_pkg::ST_OK : cosdo_pkg::ST_UNEXP;
                        end else begin
                            w_res.status    = cosdo_pkg::ST_OK;
                            w_res.read_data = w_rd_data;
                            w_res.read_len  = w_rd_len;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // ---- state, configuration and output stages ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_id  <= cosdo_pkg::NODE_ID_RST;
            r_timeout  <= cosdo_pkg::TIMEOUT_RST;
            r_busy     <= 1'b0;
            r_is_wr    <= 1'b0;
            r_idx      <= '0;
            r_sub      <= '0;
            r_ticks    <= '0;
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            r_busy  <= n_busy;
            r_is_wr <= n_is_wr;
            r_idx   <= n_idx;
            r_sub   <= n_sub;
            r_ticks <= n_ticks;

            if (w_cfg_wr) begin
                unique case (paddr[2])
                    cosdo_pkg::REG_NODE_ID: r_node_id <= pwdata[6:0];
                    cosdo_pkg::REG_TIMEOUT: r_timeout <= pwdata[15:0];
                    default: ;
                endcase
            end

            // skid entry drains first; a new result goes behind it
            if (w_out_free) begin
                if (r_skid_vld) begin
                    r_out_vld  <= 1'b1;
                    r_skid_vld <= w_has_res;
                end else begin
                    r_out_vld  <= w_has_res;
                end
            end else if (w_has_res) begin
                r_skid_vld <= 1'b1;
            end
        end
    end

    // payload of the output stages
    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            if (r_skid_vld) begin
                r_out <= r_skid;
                if (w_has_res) begin
                    r_skid <= w_res;
                end
            end else if (w_has_res) begin
                r_out <= w_res;
            end
        end else if (w_has_res) begin
            r_skid <= w_res;
        end
    end

    assign o_stall      = r_skid_vld;
    assign o_valid      = r_out_vld;
    assign o_kind       = r_out.kind;
    assign o_tx_ident   = r_out.tx_ident;
    assign o_tx_bytes   = r_out.tx_bytes;
    assign o_status     = r_out.status;
    assign o_abort_code = r_out.abort_code;
    assign o_read_data  = r_out.read_data;
    assign o_read_len   = r_out.read_len;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == cosdo_pkg::REG_TIMEOUT) ? {16'h0, r_timeout}
                                                         : {25'h0, r_node_id};

`ifndef SYNTHESIS
    // skid entry only fills behind a held output beat
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid entry valid without output beat");

    // a held output beat may not change under stall
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && i_stall) |=> (r_out_vld && $stable(r_out)))
        else $error("stalled result changed");

    // accepted read start while idle arms the transfer
    a_start_arms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !r_busy && i_cmd == cosdo_pkg::CMD_READ) |=> r_busy)
        else $error("read start did not arm transfer");

    // the transfer ends only together with a completion result
    a_end_reports: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !n_busy) |-> (w_has_res && w_res.kind == cosdo_pkg::KIND_DONE))
        else $error("transfer ended without completion result");
`endif

endmodule
